/* src/texture_residency_lru_cache_core_assert.svh */
// assertion macros for the texture residency cache
`ifndef TEXTURE_RESIDENCY_LRU_CACHE_CORE_ASSERT_SVH
`define TEXTURE_RESIDENCY_LRU_CACHE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TLRU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlru check failed");

// next-cycle implication, checked outside reset
`define TLRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlru check failed");

`endif

/* src/tlru_pkg.sv */
`default_nettype none
package tlru_pkg;

  localparam logic       CMD_LOOKUP  = 1'b0;
  localparam logic       CMD_FLUSH   = 1'b1;

  localparam logic [1:0] ACT_KEEP    = 2'd0;
  localparam logic [1:0] ACT_CREATE  = 2'd1;
  localparam logic [1:0] ACT_UPDATE  = 2'd2;
  localparam logic [1:0] ACT_FLUSHED = 2'd3;

  // one slot as held in the slot memory
  typedef struct packed {
    logic [31:0] kind;
    logic [31:0] key;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] content_version;
    logic [31:0] pixel_version;
    logic [31:0] stamp;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FIN
  } tlru_state_t;

endpackage
`default_nettype wire

/* src/texture_residency_lru_cache_core.sv */
// texture residency cache, fully associative with lru replacement
//
// input channel (in_valid/in_ready): one beat is a command. command 0 looks
// up an image by kind and key; command 1 flushes every slot.
// result channel (out_valid/out_ready): exactly one beat per input beat, in
// order, carrying slot, action, hit and evicted.
// a lookup reads every slot of the slot memory once, one slot per cycle, and
// then writes the chosen slot back; a flush skips the scan. one item is in
// work at a time.
// in_ready is high only while idle. a finished result waits in the output
// register; the next item may already be accepted and scanned, and it only
// holds in its final step while the previous result is still not taken.
// reset empties all slots at once (occupancy is kept in flip-flops) and
// clears the use counter; no clearing pass is needed.
`default_nettype none
`include "texture_residency_lru_cache_core_assert.svh"
module texture_residency_lru_cache_core
  import tlru_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [31:0] in_image_kind,
  input  wire logic [31:0] in_image_key,
  input  wire logic [15:0] in_image_width,
  input  wire logic [15:0] in_image_height,
  input  wire logic [31:0] in_content_version,
  input  wire logic [31:0] in_pixel_version,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_slot,
  output logic [1:0]       out_action,
  output logic             out_hit,
  output logic             out_evicted
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  tlru_state_t state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          rd_pend_r;
  logic [IW-1:0] rd_idx_r;
  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [31:0]   use_cnt_r, use_cnt_nxt;

  logic          req_cmd_r;
  logic [31:0]   req_kind_r, req_key_r, req_cv_r, req_pv_r;
  logic [15:0]   req_w_r, req_h_r;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_slot_r, out_slot_nxt;
  logic [1:0]    out_action_r, out_action_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic          out_evicted_r, out_evicted_nxt;

  logic          accept, out_free, scan_start;
  logic          rd_en, wr_en;
  slot_entry_t   rd_data, wr_data, hit_entry;
  logic          hit;
  logic [IW-1:0] hit_idx, old_idx, sel_idx, empty_idx;
  logic          any_empty;
  logic          resize;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // first empty slot, lowest index wins
  always_comb begin
    any_empty = 1'b0;
    empty_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ_r[i]) begin
        any_empty = 1'b1;
        empty_idx = IW'(i);
      end
    end
  end

  assign sel_idx = hit ? hit_idx : (any_empty ? empty_idx : old_idx);
  assign resize  = hit_entry.width != req_w_r || hit_entry.height != req_h_r;

  assign wr_data = '{kind: req_kind_r, key: req_key_r, width: req_w_r,
                     height: req_h_r, content_version: req_cv_r,
                     pixel_version: req_pv_r, stamp: use_cnt_r + 32'd1};

  tlru_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (sel_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data)
  );

  tlru_scan #(
    .IW (IW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .rd_valid  (rd_pend_r),
    .rd_idx    (rd_idx_r),
    .rd_occ    (occ_r[rd_idx_r]),
    .rd_data   (rd_data),
    .req_kind  (req_kind_r),
    .req_key   (req_key_r),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .hit_entry (hit_entry),
    .old_idx   (old_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      occ_r       <= '0;
      use_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_en;
      occ_r       <= occ_nxt;
      use_cnt_r   <= use_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r      <= cnt_r;
    out_slot_r    <= out_slot_nxt;
    out_action_r  <= out_action_nxt;
    out_hit_r     <= out_hit_nxt;
    out_evicted_r <= out_evicted_nxt;
    if (accept) begin
      req_cmd_r  <= in_command;
      req_kind_r <= in_image_kind;
      req_key_r  <= in_image_key;
      req_w_r    <= in_image_width;
      req_h_r    <= in_image_height;
      req_cv_r   <= in_content_version;
      req_pv_r   <= in_pixel_version;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    occ_nxt         = occ_r;
    use_cnt_nxt     = use_cnt_r;
    in_ready        = 1'b0;
    scan_start      = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_slot_nxt    = out_slot_r;
    out_action_nxt  = out_action_r;
    out_hit_nxt     = out_hit_r;
    out_evicted_nxt = out_evicted_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          scan_start = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = (in_command == CMD_FLUSH) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_WAIT;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_WAIT: begin
        // last slot read is being folded into the scan result
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_cmd_r == CMD_FLUSH) begin
            // stale memory contents are never read for an empty slot
            occ_nxt         = '0;
            out_slot_nxt    = 3'd0;
            out_action_nxt  = ACT_FLUSHED;
            out_hit_nxt     = 1'b0;
            out_evicted_nxt = 1'b0;
          end else begin
            wr_en            = 1'b1;
            occ_nxt[sel_idx] = 1'b1;
            use_cnt_nxt      = use_cnt_r + 32'd1;
            out_slot_nxt     = 3'(sel_idx);
            out_hit_nxt      = hit;
            out_evicted_nxt  = !hit && occ_r[sel_idx];
            if (!hit || resize) begin
              out_action_nxt = ACT_CREATE;
            end else if (hit_entry.content_version == req_cv_r &&
                         hit_entry.pixel_version == req_pv_r) begin
              out_action_nxt = ACT_KEEP;
            end else begin
              out_action_nxt = ACT_UPDATE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_slot    = out_slot_r;
  assign out_action  = out_action_r;
  assign out_hit     = out_hit_r;
  assign out_evicted = out_evicted_r;

  `TLRU_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
  `TLRU_ASSERT_NOW(a_flush_beat_shape, out_valid && out_action == ACT_FLUSHED,
    out_slot == 3'd0 && !out_hit && !out_evicted)
  `TLRU_ASSERT_NOW(a_hit_not_evicted, out_valid && out_hit,
    !out_evicted && out_action != ACT_FLUSHED)
  `TLRU_ASSERT_NEXT(a_flush_empties, state_r == ST_FIN && out_free && req_cmd_r == CMD_FLUSH,
    occ_r == '0)

endmodule
`default_nettype wire

/* src/tlru_slot_ram.sv */
`default_nettype none
module tlru_slot_ram
  import tlru_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_entry_t   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_entry_t        rd_data
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* src/tlru_scan.sv */
`default_nettype none
module tlru_scan
  import tlru_pkg::*;
#(
  parameter int IW = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          rd_valid,
  input  wire logic [IW-1:0] rd_idx,
  input  wire logic          rd_occ,
  input  wire slot_entry_t   rd_data,
  input  wire logic [31:0]   req_kind,
  input  wire logic [31:0]   req_key,
  output logic               hit,
  output logic [IW-1:0]      hit_idx,
  output slot_entry_t        hit_entry,
  output logic [IW-1:0]      old_idx
);

  logic        hit_r;
  logic        found_r;
  logic [IW-1:0] hit_idx_r;
  slot_entry_t hit_entry_r;
  logic [IW-1:0] old_idx_r;
  logic [31:0] old_stamp_r;
  logic        match;
  logic        older;

  assign match = rd_valid && rd_occ && !hit_r &&
                 rd_data.kind == req_kind && rd_data.key == req_key;
  // strict compare keeps the lowest index among equal stamps
  assign older = rd_valid && rd_occ && (!found_r || rd_data.stamp < old_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (start) begin
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (match) hit_r <= 1'b1;
      if (older) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      hit_idx_r   <= rd_idx;
      hit_entry_r <= rd_data;
    end
    if (older) begin
      old_idx_r   <= rd_idx;
      old_stamp_r <= rd_data.stamp;
    end
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign hit_entry = hit_entry_r;
  assign old_idx   = old_idx_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import tlru_pkg::*;

  localparam int SLOT_NUM   = 8;
  localparam int POOL       = 12;
  localparam int CYCLE_CAP  = 300000;

  typedef struct {
    logic [2:0] slot;
    logic [1:0] action;
    logic       hit;
    logic       evicted;
  } reply_t;

  // residency predictor plus the queue of replies it still owes
  class residency_board;
    localparam int SLOTS = 8;
    slot_entry_t slots[SLOTS];
    bit          occupied[SLOTS];
    bit          loaded[SLOTS];
    logic [31:0] use_count;
    reply_t      pending[$];
    int          mismatches;
    int          lookups, flushes, hits, evictions;
    int          keeps, creates, updates;

    function new();
      clear_slots();
      use_count  = '0;
      mismatches = 0;
      lookups = 0; flushes = 0; hits = 0; evictions = 0;
      keeps = 0; creates = 0; updates = 0;
    endfunction

    function void clear_slots();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slots[i]    = '0;
        occupied[i] = 1'b0;
        loaded[i]   = 1'b0;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void note_command(logic cmd, logic [31:0] kind, logic [31:0] key,
                               logic [15:0] w, logic [15:0] h,
                               logic [31:0] cv, logic [31:0] pv);
      reply_t r;
      int     s;
      int     i;
      bit     remake;
      r.slot = 3'd0;
      r.action = ACT_FLUSHED;
      r.hit = 1'b0;
      r.evicted = 1'b0;
      if (cmd == CMD_FLUSH) begin
        clear_slots();
        flushes++;
        pending.push_back(r);
        return;
      end
      lookups++;
      s = -1;
      for (i = 0; i < SLOTS; i++)
        if (s < 0 && occupied[i] && slots[i].kind == kind && slots[i].key == key) s = i;
      r.hit = (s >= 0);
      if (s < 0) begin
        for (i = 0; i < SLOTS; i++)
          if (s < 0 && !occupied[i]) s = i;
        // all full: oldest stamp wins, lowest index on ties
        if (s < 0) begin
          s = 0;
          for (i = 1; i < SLOTS; i++)
            if (slots[i].stamp < slots[s].stamp) s = i;
        end
        r.evicted       = occupied[s];
        occupied[s]     = 1'b1;
        loaded[s]       = 1'b0;
        slots[s].kind   = kind;
        slots[s].key    = key;
        slots[s].width  = '0;
        slots[s].height = '0;
      end
      use_count      = use_count + 32'd1;
      slots[s].stamp = use_count;
      remake = !loaded[s] || slots[s].width != w || slots[s].height != h;
      if (!remake && slots[s].content_version == cv && slots[s].pixel_version == pv) begin
        r.action = ACT_KEEP;
        keeps++;
      end else begin
        if (remake) begin
          slots[s].width  = w;
          slots[s].height = h;
          loaded[s]       = 1'b1;
          r.action        = ACT_CREATE;
          creates++;
        end else begin
          r.action = ACT_UPDATE;
          updates++;
        end
        slots[s].content_version = cv;
        slots[s].pixel_version   = pv;
      end
      r.slot = s[2:0];
      if (r.hit) hits++;
      if (r.evicted) evictions++;
      pending.push_back(r);
    endfunction

    function void check_reply(logic [2:0] slot, logic [1:0] action, logic hit, logic evicted);
      reply_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding: slot %0d action %0d", slot, action);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      if (slot !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, slot);
        mismatches++;
      end
      if (action !== e.action) begin
        $error("action: expected %0d, actual %0d", e.action, action);
        mismatches++;
      end
      if (hit !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, hit);
        mismatches++;
      end
      if (evicted !== e.evicted) begin
        $error("evicted: expected %0d, actual %0d", e.evicted, evicted);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [31:0] in_image_kind;
  logic [31:0] in_image_key;
  logic [15:0] in_image_width;
  logic [15:0] in_image_height;
  logic [31:0] in_content_version;
  logic [31:0] in_pixel_version;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_slot;
  logic [1:0]  out_action;
  logic        out_hit;
  logic        out_evicted;

  texture_residency_lru_cache_core #(
    .SLOT_COUNT(SLOT_NUM)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_image_kind      (in_image_kind),
    .in_image_key       (in_image_key),
    .in_image_width     (in_image_width),
    .in_image_height    (in_image_height),
    .in_content_version (in_content_version),
    .in_pixel_version   (in_pixel_version),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_slot           (out_slot),
    .out_action         (out_action),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted)
  );

  residency_board board = new();
  bit             calm = 1'b0;
  int             long_hold = 0;
  int             cycle_count = 0;

  logic [31:0] pool_kind[POOL];
  logic [31:0] pool_key[POOL];
  logic [15:0] pool_w[POOL];
  logic [15:0] pool_h[POOL];
  logic [31:0] pool_cv[POOL];
  logic [31:0] pool_pv[POOL];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && in_valid && in_ready)
      board.note_command(in_command, in_image_kind, in_image_key, in_image_width,
                         in_image_height, in_content_version, in_pixel_version);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      board.check_reply(out_slot, out_action, out_hit, out_evicted);

  // result side: random stall per beat, or one long hold when asked
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(input logic cmd, input logic [31:0] kind, key,
                           input logic [15:0] w, h, input logic [31:0] cv, pv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_image_kind      <= kind;
    in_image_key       <= key;
    in_image_width     <= w;
    in_image_height    <= h;
    in_content_version <= cv;
    in_pixel_version   <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_flush();
    send_beat(CMD_FLUSH, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom);
  endtask

  task automatic lookup_pool(input int idx);
    send_beat(CMD_LOOKUP, pool_kind[idx], pool_key[idx], pool_w[idx], pool_h[idx],
              pool_cv[idx], pool_pv[idx]);
  endtask

  task automatic new_image(input int idx);
    pool_kind[idx] = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 3));
    pool_key[idx]  = $urandom;
    pool_w[idx]    = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 64));
    pool_h[idx]    = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 64));
    pool_cv[idx]   = $urandom;
    pool_pv[idx]   = $urandom;
  endtask

  // mostly repeat lookups over a pool larger than the cache, so hits,
  // version bumps, size changes and evictions all show up
  task automatic random_beat();
    int pick;
    int idx;
    pick = $urandom_range(0, 99);
    idx  = $urandom_range(0, POOL - 1);
    if (pick < 2) begin
      send_flush();
    end else if (pick < 10) begin
      send_beat(CMD_LOOKUP, $urandom, $urandom, 16'($urandom), 16'($urandom), $urandom, $urandom);
    end else begin
      if (pick < 15) begin
        new_image(idx);
      end else if (pick < 22) begin
        pool_cv[idx] = $urandom;
      end else if (pick < 27) begin
        pool_pv[idx] = $urandom;
      end else if (pick < 33) begin
        if ($urandom_range(0, 1)) pool_w[idx] = 16'($urandom);
        else pool_h[idx] = 16'($urandom);
      end
      lookup_pool(idx);
    end
  endtask

  initial begin
    int i;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_command         = CMD_LOOKUP;
    in_image_kind      = '0;
    in_image_key       = '0;
    in_image_width     = '0;
    in_image_height    = '0;
    in_content_version = '0;
    in_pixel_version   = '0;
    for (i = 0; i < POOL; i++) new_image(i);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first load, keep, both version bumps, resize on a hit
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // same key under another kind, and the other way round, are misses
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h1, 16'h1, 32'h1, 32'h1);
    send_beat(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0,
              32'hFFFF_FFFF, 32'h0);
    for (i = 4; i < SLOT_NUM; i++)
      send_beat(CMD_LOOKUP, 32'(i), $urandom, 16'(i), 16'(i), 32'(i), 32'(i));
    // cache full: the first two evict the least recently stamped slots, the third hits
    send_beat(CMD_LOOKUP, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 16'h1234, 16'h4321, 32'h7, 32'h8);
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0,
              32'hFFFF_FFFF, 32'h0);
    send_flush();
    // after a flush the same key loads afresh into slot 0
    send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0,
              32'hFFFF_FFFF, 32'h0);
    send_flush();
    send_flush();
    send_beat(CMD_LOOKUP, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0);

    for (i = 0; i < 300; i++) random_beat();

    // hold the result side off and keep offering until the input stalls
    long_hold = 150;
    for (i = 0; i < 20; i++) random_beat();

    // sender drains the block completely before going on
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);

    calm = 1'b1;
    for (i = 0; i < 60; i++) random_beat();
    calm = 1'b0;
    for (i = 0; i < 250; i++) random_beat();

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d lookups (%0d hits, %0d evictions) and %0d flushes",
             board.lookups, board.hits, board.evictions, board.flushes);
    $display("actions predicted: keep %0d, create %0d, update %0d",
             board.keeps, board.creates, board.updates);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
